// ===== src/ptt_pkg.sv =====
// Shared types and codes for the periodic timer table.
`timescale 1ns / 1ps

package ptt_pkg;

  localparam int unsigned OwnerW = 16;
  localparam int unsigned WordW  = 32;
  localparam int unsigned TimeW  = 64;
  localparam int unsigned KindW  = 3;
  localparam int unsigned FuncW  = 2;

  localparam int unsigned InDataW  = 208;
  localparam int unsigned OutDataW = 144;

  localparam logic [FuncW-1:0] FUNC_SET    = 2'd0;
  localparam logic [FuncW-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FuncW-1:0] FUNC_TICK   = 2'd2;

  localparam logic [KindW-1:0] KIND_SET_DONE = 3'd0;
  localparam logic [KindW-1:0] KIND_REMOVED  = 3'd1;
  localparam logic [KindW-1:0] KIND_FIRED    = 3'd2;
  localparam logic [KindW-1:0] KIND_NO_FIRE  = 3'd3;
  localparam logic [KindW-1:0] KIND_FULL     = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FREE,
    S_ORD,
    S_SLOT,
    S_EVAL,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic load;       // latch the request beat, initialise the scan
    logic free_next;  // step the free slot search
    logic insert;     // write the new timer into the free slot
    logic set_full;   // queue the table full result
    logic ord_rd;     // read the order list at the scan index
    logic slot_rd;    // read the slot that the order list names
    logic eval;       // act on the slot and step the scan
    logic flush;      // send the final result of the request
  } cmd_t;

  typedef struct packed {
    logic full;
    logic count_zero;
    logic free_hit;
    logic scan_last;
    logic eval_stall;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [WordW-1:0]  id;
    logic [OwnerW-1:0] owner;
    logic [WordW-1:0]  entry;
    logic [WordW-1:0]  data;
  } res_t;

endpackage

// ===== src/periodic_timer_table_core.sv =====
// Periodic timer table: a per-timer scan over on-chip slot storage.
// Set searches for a free slot, one slot a cycle; remove and tick scan each live timer
// in turn through an order list read, a slot RAM read and an evaluate step. Results leave
// through one output register.
// Throughput: one request at a time; in_tready is high only between requests.
// Reset clears valid and started bits, the timer count, the id counter (to 1) and the
// smallest period; slot contents are not cleared.
`timescale 1ns / 1ps

module periodic_timer_table_core #(
  parameter int unsigned NUM_TIMERS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // owner[15:0], period_usec[47:16], entry_word[79:48], user_data[111:80],
  // timer_id[143:112], now_usec[207:144]
  input  logic [ptt_pkg::InDataW-1:0]  in_tdata,
  // func[1:0]
  input  logic [ptt_pkg::FuncW-1:0]    in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // assigned_id[31:0], fire_owner[47:32], fire_entry[79:48], fire_data[111:80],
  // min_period[143:112]
  output logic [ptt_pkg::OutDataW-1:0] out_tdata,
  // kind[2:0]
  output logic [ptt_pkg::KindW-1:0]    out_tuser,
  output logic                         out_tlast
);

  ptt_pkg::cmd_t    cmd;
  ptt_pkg::status_t st;

  ptt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_func   (in_tuser),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  ptt_dp #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_func    (in_tuser),
    .in_data    (in_tdata),
    .cmd        (cmd),
    .st         (st),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_data   (out_tdata),
    .out_kind   (out_tuser),
    .out_last   (out_tlast)
  );

endmodule

// ===== src/ptt_ctrl.sv =====
// Request sequencer for the periodic timer table.
`timescale 1ns / 1ps

module ptt_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  input  logic [ptt_pkg::FuncW-1:0] in_func,
  output logic                     in_tready,
  input  ptt_pkg::status_t         st,
  output ptt_pkg::cmd_t            cmd
);

  ptt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ptt_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          priority case (in_func)
            ptt_pkg::FUNC_SET:    state_nxt = ptt_pkg::S_FREE;
            ptt_pkg::FUNC_REMOVE,
            ptt_pkg::FUNC_TICK:   state_nxt = st.count_zero ? ptt_pkg::S_FLUSH : ptt_pkg::S_ORD;
            default:              state_nxt = ptt_pkg::S_IDLE;
          endcase
        end
      end
      ptt_pkg::S_FREE: begin
        if (st.full) begin
          cmd.set_full = 1'b1;
          state_nxt    = ptt_pkg::S_FLUSH;
        end else if (st.free_hit) begin
          cmd.insert = 1'b1;
          state_nxt  = ptt_pkg::S_FLUSH;
        end else begin
          cmd.free_next = 1'b1;
        end
      end
      ptt_pkg::S_ORD: begin
        cmd.ord_rd = 1'b1;
        state_nxt  = ptt_pkg::S_SLOT;
      end
      ptt_pkg::S_SLOT: begin
        cmd.slot_rd = 1'b1;
        state_nxt   = ptt_pkg::S_EVAL;
      end
      ptt_pkg::S_EVAL: begin
        // a second firing waits until the held one can leave
        if (!st.eval_stall) begin
          cmd.eval  = 1'b1;
          state_nxt = st.scan_last ? ptt_pkg::S_FLUSH : ptt_pkg::S_ORD;
        end
      end
      ptt_pkg::S_FLUSH: begin
        if (st.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = ptt_pkg::S_IDLE;
        end
      end
      default: state_nxt = ptt_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== src/ptt_dp.sv =====
// Timer storage, order list, scan counters and result register.
`timescale 1ns / 1ps

module ptt_dp #(
  parameter int unsigned NUM_TIMERS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [ptt_pkg::FuncW-1:0]    in_func,
  input  logic [ptt_pkg::InDataW-1:0]  in_data,
  input  ptt_pkg::cmd_t                cmd,
  output ptt_pkg::status_t             st,
  input  logic                         out_tready,
  output logic                         out_tvalid,
  output logic [ptt_pkg::OutDataW-1:0] out_data,
  output logic [ptt_pkg::KindW-1:0]    out_kind,
  output logic                         out_last
);

  localparam int unsigned IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned CW = $clog2(NUM_TIMERS + 1);

  localparam int unsigned OW = ptt_pkg::OwnerW;
  localparam int unsigned WW = ptt_pkg::WordW;
  localparam int unsigned TW = ptt_pkg::TimeW;

  // request registers
  logic [ptt_pkg::FuncW-1:0] func_r;
  logic [OW-1:0] owner_r;
  logic [WW-1:0] period_r, entry_r, udata_r, tid_r;
  logic [TW-1:0] now_r;

  // control state
  logic [CW-1:0] count_r, kept_r;
  logic [IW-1:0] idx_r, free_idx_r, s_r;
  logic [WW-1:0] next_id_r, min_r;
  logic [NUM_TIMERS-1:0] valid_r, started_r;
  logic pend_valid_r;
  ptt_pkg::res_t pend_r;
  logic out_valid_r;
  ptt_pkg::res_t out_res_r;
  logic [WW-1:0] out_min_r;
  logic out_last_r;

  // slot storage and order list (oldest first)
  logic [OW-1:0] m_owner [NUM_TIMERS];
  logic [WW-1:0] m_id    [NUM_TIMERS];
  logic [WW-1:0] m_period[NUM_TIMERS];
  logic [WW-1:0] m_entry [NUM_TIMERS];
  logic [WW-1:0] m_data  [NUM_TIMERS];
  logic [TW-1:0] m_last  [NUM_TIMERS];
  logic [IW-1:0] m_ord   [NUM_TIMERS];

  logic [OW-1:0] q_owner;
  logic [WW-1:0] q_id, q_period, q_entry, q_data;
  logic [TW-1:0] q_last;
  logic [IW-1:0] q_ord;

  logic is_tick, is_remove;
  logic match, started, due, fire, kept;
  logic [TW-1:0] elapsed;
  logic [CW-1:0] count_m1, idx_ext;
  logic out_free;
  logic [WW-1:0] id_inc;
  logic [WW-1:0] cand;
  logic cand_lower;
  logic push_fire, push_final;
  ptt_pkg::res_t final_res;

  assign is_tick   = (func_r == ptt_pkg::FUNC_TICK);
  assign is_remove = (func_r == ptt_pkg::FUNC_REMOVE);

  assign match   = (q_owner == owner_r) && ((tid_r == '0) || (q_id == tid_r));
  assign started = started_r[s_r];
  assign elapsed = now_r - q_last;
  assign due     = (elapsed >= {{(TW-WW){1'b0}}, q_period});
  assign fire    = is_tick && started && due;
  assign kept    = is_remove && !match;

  assign count_m1 = count_r - CW'(1);
  assign idx_ext  = CW'(idx_r) + CW'(1);
  assign out_free = !out_valid_r || out_tready;
  assign id_inc   = next_id_r + WW'(1);

  // candidate for the smallest nonzero period
  assign cand       = cmd.insert ? period_r : q_period;
  assign cand_lower = (cand != '0) && ((min_r == '0) || (cand < min_r));

  assign push_fire  = cmd.eval && fire && pend_valid_r;
  assign push_final = cmd.flush;

  always_comb begin
    final_res = '0;
    if (pend_valid_r) begin
      final_res = pend_r;
    end else if (is_remove) begin
      final_res.kind = ptt_pkg::KIND_REMOVED;
    end else begin
      final_res.kind = ptt_pkg::KIND_NO_FIRE;
    end
  end

  assign st.full       = (count_r == CW'(NUM_TIMERS));
  assign st.count_zero = (count_r == '0);
  assign st.free_hit   = !valid_r[free_idx_r];
  assign st.scan_last  = is_tick ? (idx_r == '0) : (idx_ext == count_r);
  assign st.eval_stall = fire && pend_valid_r && !out_free;
  assign st.out_free   = out_free;

  // memories
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      m_owner[free_idx_r]  <= owner_r;
      m_id[free_idx_r]     <= next_id_r;
      m_period[free_idx_r] <= period_r;
      m_entry[free_idx_r]  <= entry_r;
      m_data[free_idx_r]   <= udata_r;
    end
    if (cmd.slot_rd) begin
      q_owner  <= m_owner[q_ord];
      q_id     <= m_id[q_ord];
      q_period <= m_period[q_ord];
      q_entry  <= m_entry[q_ord];
      q_data   <= m_data[q_ord];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      m_last[free_idx_r] <= '0;
    end else if (cmd.eval && is_tick && (!started || due)) begin
      m_last[s_r] <= now_r;
    end
    if (cmd.slot_rd) begin
      q_last <= m_last[q_ord];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      m_ord[count_r[IW-1:0]] <= free_idx_r;
    end else if (cmd.eval && kept) begin
      m_ord[kept_r[IW-1:0]] <= s_r;
    end
    if (cmd.ord_rd) begin
      q_ord <= m_ord[idx_r];
    end
  end

  // request payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r   <= in_func;
      owner_r  <= in_data[15:0];
      period_r <= in_data[47:16];
      entry_r  <= in_data[79:48];
      udata_r  <= in_data[111:80];
      tid_r    <= in_data[143:112];
      now_r    <= in_data[207:144];
    end
    if (cmd.slot_rd) begin
      s_r <= q_ord;
    end
    if (cmd.eval && fire) begin
      pend_r.kind  <= ptt_pkg::KIND_FIRED;
      pend_r.id    <= '0;
      pend_r.owner <= q_owner;
      pend_r.entry <= q_entry;
      pend_r.data  <= q_data;
    end else if (cmd.insert) begin
      pend_r <= '{kind: ptt_pkg::KIND_SET_DONE, id: next_id_r, owner: '0, entry: '0,
                  data: '0};
    end else if (cmd.set_full) begin
      pend_r <= '{kind: ptt_pkg::KIND_FULL, id: '0, owner: '0, entry: '0, data: '0};
    end
    if (push_fire) begin
      out_res_r  <= pend_r;
      out_min_r  <= min_r;
      out_last_r <= 1'b0;
    end else if (push_final) begin
      out_res_r  <= final_res;
      out_min_r  <= min_r;
      out_last_r <= 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      kept_r       <= '0;
      idx_r        <= '0;
      free_idx_r   <= '0;
      next_id_r    <= WW'(1);
      min_r        <= '0;
      valid_r      <= '0;
      started_r    <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        kept_r       <= '0;
        free_idx_r   <= '0;
        pend_valid_r <= 1'b0;
        idx_r        <= (in_func == ptt_pkg::FUNC_TICK) ? count_m1[IW-1:0] : '0;
        if (in_func == ptt_pkg::FUNC_REMOVE) begin
          min_r <= '0;
        end
      end
      if (cmd.free_next) begin
        free_idx_r <= free_idx_r + IW'(1);
      end
      if (cmd.insert) begin
        valid_r[free_idx_r]   <= 1'b1;
        started_r[free_idx_r] <= 1'b0;
        count_r               <= count_r + CW'(1);
        next_id_r             <= (id_inc == '0) ? WW'(1) : id_inc;
        pend_valid_r          <= 1'b1;
        if (cand_lower) begin
          min_r <= cand;
        end
      end
      if (cmd.set_full) begin
        pend_valid_r <= 1'b1;
      end
      if (cmd.eval) begin
        idx_r <= is_tick ? (idx_r - IW'(1)) : (idx_r + IW'(1));
        if (is_remove) begin
          if (match) begin
            valid_r[s_r]   <= 1'b0;
            started_r[s_r] <= 1'b0;
          end else begin
            kept_r <= kept_r + CW'(1);
            if (cand_lower) begin
              min_r <= cand;
            end
          end
        end else if (!started) begin
          started_r[s_r] <= 1'b1;
        end
        if (fire) begin
          pend_valid_r <= 1'b1;
        end
      end
      if (cmd.flush && is_remove) begin
        count_r <= kept_r;
      end
      if (push_fire || push_final) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_kind   = out_res_r.kind;
  assign out_last   = out_last_r;
  assign out_data   = {out_min_r, out_res_r.data, out_res_r.entry,
                       out_res_r.owner, out_res_r.id};

endmodule
